### hw/rtl/aqet_pkg.sv
// Shared types, constants and fixed-point helpers for the escape-time evaluator.
package aqet_pkg;

    // Fixed-point format and limits.
    localparam int unsigned FRAC_BITS = 26;
    localparam int unsigned MAX_DIM   = 4096;
    localparam int unsigned SIZE_W    = 13;
    localparam int unsigned ITER_W    = 16;
    localparam int unsigned PIX_W     = 24;
    localparam int unsigned COORD_W   = 12;
    localparam int unsigned ADDR_W    = 5;

    localparam logic signed [63:0] Q_MAX     = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN     = -64'sd2147483648;
    localparam logic signed [63:0] ESC_LIMIT = 64'sd5 <<< FRAC_BITS;

    // Register map, one 32-bit word per register.
    typedef enum logic [2:0] {
        REG_MAX_ITER  = 3'd0,
        REG_WIDTH     = 3'd1,
        REG_HEIGHT    = 3'd2,
        REG_CENTER_RE = 3'd3,
        REG_CENTER_IM = 3'd4,
        REG_SPAN_RE   = 3'd5,
        REG_SPAN_IM   = 3'd6,
        REG_ZOOM      = 3'd7
    } t_reg_idx;

    // View settings used by the point mapper.
    typedef struct packed {
        logic signed [31:0] center_re;
        logic signed [31:0] center_im;
        logic signed [31:0] span_re;
        logic signed [31:0] span_im;
        logic signed [31:0] zoom;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
    } t_view_cfg;

    // A mapped point waiting for the iteration engine.
    typedef struct packed {
        logic signed [31:0] cre;
        logic signed [31:0] cim;
        logic [PIX_W-1:0]   pixel_index;
    } t_point;

    // One finished pixel.
    typedef struct packed {
        logic [ITER_W-1:0] escape_count;
        logic [PIX_W-1:0]  pixel_index;
    } t_result;

    // Saturate a wide value to the signed 32-bit range.
    function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > Q_MAX) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < Q_MIN) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Rescale an exact product: floor shift by the fraction bits, then saturate.
    function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
        logic signed [63:0] shifted;
        shifted = p >>> FRAC_BITS;
        return sat_q(shifted);
    endfunction

endpackage

### hw/rtl/aqet_queue.sv
// Small first-in first-out queue built from registers.
module aqet_queue #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic              wr_en;
    logic              rd_en;

    // Handshake status.
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push & ~o_full;
    assign rd_en   = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer wrap.
    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hw/rtl/aqet_front.sv
// Point mapper: turns a pixel position into a complex point and a buffer index.
module aqet_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  aqet_pkg::t_view_cfg         i_cfg,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [aqet_pkg::COORD_W-1:0] i_column,
    input  logic [aqet_pkg::COORD_W-1:0] i_row,
    output logic                        o_push,
    input  logic                        i_full,
    output aqet_pkg::t_point            o_point
);

    localparam int unsigned SIZE_W = aqet_pkg::SIZE_W;
    localparam int unsigned PIX_W  = aqet_pkg::PIX_W;
    localparam int unsigned N_W    = SIZE_W + 2;
    localparam int unsigned PROD_W = 32 + N_W;
    localparam int unsigned MAG_W  = PROD_W;
    localparam int unsigned REM_W  = SIZE_W + 1;
    localparam int unsigned BIT_W  = $clog2(MAG_W);

    typedef enum logic [6:0] {
        F_IDLE  = 7'b0000001,
        F_MUL   = 7'b0000010,
        F_SAT   = 7'b0000100,
        F_SCALE = 7'b0001000,
        F_DIV   = 7'b0010000,
        F_ADD   = 7'b0100000,
        F_PUSH  = 7'b1000000
    } t_front_state;

    t_front_state                r_state;
    logic [aqet_pkg::COORD_W-1:0] r_col;
    logic [aqet_pkg::COORD_W-1:0] r_row;
    logic                        r_axis;
    logic signed [63:0]          r_wide;
    logic signed [31:0]          r_p;
    logic                        r_neg;
    logic [MAG_W-1:0]            r_quo;
    logic [REM_W-1:0]            r_rem;
    logic [BIT_W-1:0]            r_bit;
    logic signed [31:0]          r_cre;
    logic signed [31:0]          r_cim;
    logic [PIX_W-1:0]            r_pix;

    logic [SIZE_W-1:0]           w_c;
    logic [SIZE_W-1:0]           h_c;
    logic [SIZE_W-1:0]           size_a;
    logic [aqet_pkg::COORD_W-1:0] idx_a;
    logic signed [31:0]          span_a;
    logic signed [31:0]          center_a;
    logic signed [N_W-1:0]       n_a;
    logic signed [PROD_W-1:0]    prod_c;
    logic [MAG_W-1:0]            mag_c;
    logic [REM_W:0]              div_c;
    logic [REM_W:0]              rem_sh;
    logic                        q_bit;
    logic signed [63:0]          off_c;
    logic signed [63:0]          sum_c;
    logic [PIX_W-1:0]            pix_c;

    // Size of zero counts as one; sizes above the maximum are clipped.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] res;
        if (s == '0) begin
            res = SIZE_W'(1);
        end else if (32'(s) > 32'(aqet_pkg::MAX_DIM)) begin
            res = SIZE_W'(aqet_pkg::MAX_DIM);
        end else begin
            res = s;
        end
        return res;
    endfunction

    assign w_c = clamp_size(i_cfg.width);
    assign h_c = clamp_size(i_cfg.height);

    // Per-axis operand selection: real axis first, then imaginary.
    assign size_a   = r_axis ? h_c : w_c;
    assign idx_a    = r_axis ? r_row : r_col;
    assign span_a   = r_axis ? i_cfg.span_im : i_cfg.span_re;
    assign center_a = r_axis ? i_cfg.center_im : i_cfg.center_re;

    // Numerator factor 2*index - size and the scaled product.
    assign n_a    = $signed({2'b00, idx_a, 1'b0}) - $signed({2'b00, size_a});
    assign prod_c = PROD_W'(r_p) * PROD_W'(n_a);
    assign mag_c  = prod_c[PROD_W-1] ? MAG_W'(-prod_c) : MAG_W'(prod_c);

    // One restoring division step per cycle by 2*size.
    assign div_c  = {1'b0, size_a, 1'b0};
    assign rem_sh = {r_rem, r_quo[MAG_W-1]};
    assign q_bit  = (rem_sh >= div_c);

    // Signed offset added to the center with saturation.
    assign off_c = r_neg ? -$signed({{(64 - MAG_W){1'b0}}, r_quo})
                         : $signed({{(64 - MAG_W){1'b0}}, r_quo});
    assign sum_c = 64'(center_a) + off_c;

    // Row-flipped buffer index, modulo the index width.
    assign pix_c = (PIX_W'(h_c) - PIX_W'(r_row) - PIX_W'(1)) * PIX_W'(w_c) + PIX_W'(r_col);

    assign o_full  = (r_state != F_IDLE);
    assign o_push  = (r_state == F_PUSH);
    assign o_point = '{cre: r_cre, cim: r_cim, pixel_index: r_pix};

    // Control sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_axis  <= 1'b0;
            r_bit   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_axis  <= 1'b0;
                        r_state <= F_MUL;
                    end
                end
                F_MUL:   r_state <= F_SAT;
                F_SAT:   r_state <= F_SCALE;
                F_SCALE: begin
                    r_bit   <= '0;
                    r_state <= F_DIV;
                end
                F_DIV: begin
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == BIT_W'(MAG_W - 1)) begin
                        r_state <= F_ADD;
                    end
                end
                F_ADD: begin
                    if (!r_axis) begin
                        r_axis  <= 1'b1;
                        r_state <= F_MUL;
                    end else begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (i_push) begin
                    r_col <= i_column;
                    r_row <= i_row;
                end
            end
            F_MUL: begin
                r_wide <= 64'(i_cfg.zoom) * 64'(span_a);
                if (!r_axis) begin
                    r_pix <= pix_c;
                end
            end
            F_SAT: r_p <= aqet_pkg::qscale(r_wide);
            F_SCALE: begin
                r_neg <= prod_c[PROD_W-1];
                r_quo <= mag_c;
                r_rem <= '0;
            end
            F_DIV: begin
                r_quo <= {r_quo[MAG_W-2:0], q_bit};
                r_rem <= q_bit ? REM_W'(rem_sh - div_c) : REM_W'(rem_sh);
            end
            F_ADD: begin
                if (!r_axis) begin
                    r_cre <= aqet_pkg::sat_q(sum_c);
                end else begin
                    r_cim <= aqet_pkg::sat_q(sum_c);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### hw/rtl/aqet_back.sv
// Iteration engine: runs the absolute-value quadratic map until escape or limit.
module aqet_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [aqet_pkg::ITER_W-1:0] i_max_iter,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  aqet_pkg::t_point            i_point,
    output logic                        o_push,
    input  logic                        i_full,
    output aqet_pkg::t_result           o_result
);

    localparam int unsigned ITER_W = aqet_pkg::ITER_W;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_UPD  = 4'b0100,
        B_DONE = 4'b1000
    } t_back_state;

    t_back_state                r_state;
    logic signed [31:0]         r_cre;
    logic signed [31:0]         r_cim;
    logic [aqet_pkg::PIX_W-1:0] r_pix;
    logic signed [31:0]         r_x;
    logic signed [31:0]         r_y;
    logic signed [63:0]         r_pxx;
    logic signed [63:0]         r_pyy;
    logic signed [63:0]         r_pxy;
    logic [ITER_W-1:0]          r_k;
    logic                       r_first;
    logic [ITER_W-1:0]          r_count;

    logic signed [31:0]         xx;
    logic signed [31:0]         yy;
    logic signed [31:0]         xy;
    logic signed [63:0]         sum_sq;
    logic signed [63:0]         axy;
    logic signed [31:0]         nx_c;
    logic signed [31:0]         ny_c;
    logic                       escaped;
    logic                       at_limit;

    // Rescaled squares and cross product of the current point.
    assign xx     = aqet_pkg::qscale(r_pxx);
    assign yy     = aqet_pkg::qscale(r_pyy);
    assign xy     = aqet_pkg::qscale(r_pxy);
    assign sum_sq = 64'(xx) + 64'(yy);
    assign axy    = (xy < 0) ? -64'(xy) : 64'(xy);

    // Next point of the map.
    assign nx_c = aqet_pkg::sat_q(64'(xx) - 64'(yy) - 64'(r_cre));
    assign ny_c = aqet_pkg::sat_q((axy <<< 1) - 64'(r_cim));

    assign escaped  = (sum_sq > aqet_pkg::ESC_LIMIT);
    assign at_limit = (({1'b0, r_k} + 1'b1) == {1'b0, i_max_iter});

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign o_push   = (r_state == B_DONE);
    assign o_result = '{escape_count: r_count, pixel_index: r_pix};

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_state <= (i_max_iter == '0) ? B_DONE : B_MUL;
                    end
                end
                B_MUL: r_state <= B_UPD;
                B_UPD: begin
                    priority if (r_first) begin
                        r_state <= B_MUL;
                    end else if (escaped || at_limit) begin
                        r_state <= B_DONE;
                    end else begin
                        r_state <= B_MUL;
                    end
                end
                B_DONE: begin
                    if (!i_full) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    r_cre   <= i_point.cre;
                    r_cim   <= i_point.cim;
                    r_pix   <= i_point.pixel_index;
                    r_x     <= '0;
                    r_y     <= '0;
                    r_k     <= '0;
                    r_first <= 1'b1;
                    r_count <= '0;
                end
            end
            B_MUL: begin
                r_pxx <= 64'(r_x) * 64'(r_x);
                r_pyy <= 64'(r_y) * 64'(r_y);
                r_pxy <= 64'(r_x) * 64'(r_y);
            end
            B_UPD: begin
                priority if (r_first) begin
                    r_x     <= nx_c;
                    r_y     <= ny_c;
                    r_first <= 1'b0;
                end else if (escaped) begin
                    r_count <= r_k;
                end else if (at_limit) begin
                    r_count <= '0;
                end else begin
                    r_x <= nx_c;
                    r_y <= ny_c;
                    r_k <= r_k + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### hw/rtl/abs_quadratic_escape_time.sv
// Top level of the escape-time evaluator: register port, point mapper, queues, engine.
// Point mapper: per axis, zoom*span times (2*index - size), divided by 2*size, plus center;
// the quotient comes from a restoring divider of 47 bits. The mapper takes a new pixel only
// after pushing the last point, and the engine a new point only after pushing its result;
// a zero iteration limit skips the engine loop. Reset: synchronous, active low; empties both
// queues, idles both state machines and loads the default view and iteration limit.
module abs_quadratic_escape_time (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aqet_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic [aqet_pkg::COORD_W-1:0] i_column,
    input  logic [aqet_pkg::COORD_W-1:0] i_row,
    output logic                         empty,
    input  logic                         pop,
    output logic [aqet_pkg::ITER_W-1:0]  o_escape_count,
    output logic [aqet_pkg::PIX_W-1:0]   o_pixel_index
);

    localparam int unsigned QUEUE_DEPTH = 2;

    logic [aqet_pkg::ITER_W-1:0] r_max_iter;
    logic [aqet_pkg::SIZE_W-1:0] r_width;
    logic [aqet_pkg::SIZE_W-1:0] r_height;
    logic signed [31:0]          r_center_re;
    logic signed [31:0]          r_center_im;
    logic signed [31:0]          r_span_re;
    logic signed [31:0]          r_span_im;
    logic signed [31:0]          r_zoom;

    aqet_pkg::t_reg_idx  reg_idx;
    logic                cfg_wr;
    aqet_pkg::t_view_cfg view_cfg;

    logic                front_push;
    logic                mid_full;
    logic                mid_pop;
    logic                mid_empty;
    aqet_pkg::t_point    front_point;
    aqet_pkg::t_point    mid_point;
    logic                back_push;
    logic                out_full;
    aqet_pkg::t_result   back_res;
    aqet_pkg::t_result   out_res;

    // Register port: every transaction completes in its access cycle.
    assign pready  = 1'b1;
    assign reg_idx = aqet_pkg::t_reg_idx'(paddr[aqet_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter  <= 16'd256;
            r_width     <= 13'd1024;
            r_height    <= 13'd1024;
            r_center_re <= '0;
            r_center_im <= '0;
            r_span_re   <= 32'sd67108864;
            r_span_im   <= 32'sd67108864;
            r_zoom      <= 32'sd134217728;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                aqet_pkg::REG_MAX_ITER:  r_max_iter  <= pwdata[aqet_pkg::ITER_W-1:0];
                aqet_pkg::REG_WIDTH:     r_width     <= pwdata[aqet_pkg::SIZE_W-1:0];
                aqet_pkg::REG_HEIGHT:    r_height    <= pwdata[aqet_pkg::SIZE_W-1:0];
                aqet_pkg::REG_CENTER_RE: r_center_re <= pwdata;
                aqet_pkg::REG_CENTER_IM: r_center_im <= pwdata;
                aqet_pkg::REG_SPAN_RE:   r_span_re   <= pwdata;
                aqet_pkg::REG_SPAN_IM:   r_span_im   <= pwdata;
                aqet_pkg::REG_ZOOM:      r_zoom      <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (reg_idx)
            aqet_pkg::REG_MAX_ITER:  prdata = 32'(r_max_iter);
            aqet_pkg::REG_WIDTH:     prdata = 32'(r_width);
            aqet_pkg::REG_HEIGHT:    prdata = 32'(r_height);
            aqet_pkg::REG_CENTER_RE: prdata = r_center_re;
            aqet_pkg::REG_CENTER_IM: prdata = r_center_im;
            aqet_pkg::REG_SPAN_RE:   prdata = r_span_re;
            aqet_pkg::REG_SPAN_IM:   prdata = r_span_im;
            aqet_pkg::REG_ZOOM:      prdata = r_zoom;
            default:                 prdata = '0;
        endcase
    end

    assign view_cfg = '{center_re: r_center_re, center_im: r_center_im,
                        span_re: r_span_re, span_im: r_span_im, zoom: r_zoom,
                        width: r_width, height: r_height};

    // Point mapper.
    aqet_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (view_cfg),
        .i_push   (push),
        .o_full   (full),
        .i_column (i_column),
        .i_row    (i_row),
        .o_push   (front_push),
        .i_full   (mid_full),
        .o_point  (front_point)
    );

    // Queue of mapped points between mapper and engine.
    aqet_queue #(
        .DATA_W ($bits(aqet_pkg::t_point)),
        .DEPTH  (QUEUE_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_point),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_point),
        .o_empty (mid_empty)
    );

    // Iteration engine.
    aqet_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_max_iter (r_max_iter),
        .i_empty    (mid_empty),
        .o_pop      (mid_pop),
        .i_point    (mid_point),
        .o_push     (back_push),
        .i_full     (out_full),
        .o_result   (back_res)
    );

    // Result queue toward the consumer.
    aqet_queue #(
        .DATA_W ($bits(aqet_pkg::t_result)),
        .DEPTH  (QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_escape_count = out_res.escape_count;
    assign o_pixel_index  = out_res.pixel_index;

    // An accepted pixel keeps the mapper busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("mapper took a pixel but did not go busy");

    // A mapped point offered to a full queue is held unchanged until it is taken.
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_push && mid_full) |=> (front_push && $stable(front_point)))
        else $error("mapped point dropped or changed while the queue was full");

    // A result offered to a full queue is held unchanged until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_push && out_full) |=> (back_push && $stable(back_res)))
        else $error("result dropped or changed while the queue was full");

    // An escape count is either zero or lies below the iteration limit.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_push |-> ((back_res.escape_count == '0) ||
                       (back_res.escape_count < r_max_iter)))
        else $error("escape count at or beyond the iteration limit");

endmodule

### tb/sv/abs_quadratic_escape_time_test.sv
// Self-checking testbench for the escape-time evaluator, with its own pixel predictor.
`timescale 1ns / 100ps

module abs_quadratic_escape_time_test;

    localparam int ONE_Q       = 1 << aqet_pkg::FRAC_BITS;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_PIXELS = 750;

    // Tracks the view settings and the pixel results still owed by the block.
    class escape_tracker;
        aqet_pkg::t_result           owed_pixels[$];
        logic [aqet_pkg::ITER_W-1:0] iter_limit;
        logic [aqet_pkg::SIZE_W-1:0] width_reg;
        logic [aqet_pkg::SIZE_W-1:0] height_reg;
        int                          center_re_q;
        int                          center_im_q;
        int                          span_re_q;
        int                          span_im_q;
        int                          zoom_q;
        int                          mismatches;

        function new();
            iter_limit  = 16'd256;
            width_reg   = 13'd1024;
            height_reg  = 13'd1024;
            center_re_q = 0;
            center_im_q = 0;
            span_re_q   = ONE_Q;
            span_im_q   = ONE_Q;
            zoom_q      = 2 * ONE_Q;
            mismatches  = 0;
        endfunction

        // Mirror a register write, keeping only the bits the register holds.
        function void set_register(aqet_pkg::t_reg_idx idx, logic [31:0] value);
            case (idx)
                aqet_pkg::REG_MAX_ITER:  iter_limit  = value[aqet_pkg::ITER_W-1:0];
                aqet_pkg::REG_WIDTH:     width_reg   = value[aqet_pkg::SIZE_W-1:0];
                aqet_pkg::REG_HEIGHT:    height_reg  = value[aqet_pkg::SIZE_W-1:0];
                aqet_pkg::REG_CENTER_RE: center_re_q = value;
                aqet_pkg::REG_CENTER_IM: center_im_q = value;
                aqet_pkg::REG_SPAN_RE:   span_re_q   = value;
                aqet_pkg::REG_SPAN_IM:   span_im_q   = value;
                aqet_pkg::REG_ZOOM:      zoom_q      = value;
                default: ;
            endcase
        endfunction

        function longint clamp_q(longint v);
            longint res;
            res = v;
            if (v > aqet_pkg::Q_MAX) res = aqet_pkg::Q_MAX;
            if (v < aqet_pkg::Q_MIN) res = aqet_pkg::Q_MIN;
            return res;
        endfunction

        // Exact product, floor shift to the fixed-point scale, then saturation.
        function longint qmul(longint a, longint b);
            longint prod;
            prod = a * b;
            return clamp_q(prod >>> aqet_pkg::FRAC_BITS);
        endfunction

        // A size of zero counts as one, and sizes above the maximum are capped.
        function longint view_size(logic [aqet_pkg::SIZE_W-1:0] s);
            longint res;
            res = s;
            if (s == 0) res = 1;
            if (s > aqet_pkg::MAX_DIM) res = aqet_pkg::MAX_DIM;
            return res;
        endfunction

        function longint map_axis(longint center, longint span, longint idx, longint size);
            longint scale;
            longint off;
            scale = qmul(zoom_q, span);
            off = (scale * (2 * idx - size)) / (2 * size);
            return clamp_q(center + off);
        endfunction

        function aqet_pkg::t_result escape_of(logic [aqet_pkg::COORD_W-1:0] col,
                                              logic [aqet_pkg::COORD_W-1:0] row);
            longint            w, h, cre, cim, x, y, xx, yy, xy, addr;
            int unsigned       k;
            aqet_pkg::t_result res;
            w   = view_size(width_reg);
            h   = view_size(height_reg);
            cre = map_axis(center_re_q, span_re_q, longint'(col), w);
            cim = map_axis(center_im_q, span_im_q, longint'(row), h);
            x = 0;
            y = 0;
            for (k = 0; k < iter_limit; k++) begin
                xx = qmul(x, x);
                yy = qmul(y, y);
                xy = qmul(x, y);
                if (xy < 0) xy = -xy;
                x = clamp_q(xx - yy - cre);
                y = clamp_q(2 * xy - cim);
                if (qmul(x, x) + qmul(y, y) > aqet_pkg::ESC_LIMIT) break;
            end
            res.escape_count = (k == iter_limit) ? '0 : aqet_pkg::ITER_W'(k);
            // Row-flipped address; wraps when the index lies beyond the view.
            addr = (h - longint'(row) - 1) * w + longint'(col);
            res.pixel_index = aqet_pkg::PIX_W'(addr);
            return res;
        endfunction

        function void note_pixel(logic [aqet_pkg::COORD_W-1:0] col,
                                 logic [aqet_pkg::COORD_W-1:0] row);
            owed_pixels.push_back(escape_of(col, row));
        endfunction

        // Compare one popped result with the oldest pixel still owed.
        function void check_pixel(logic [aqet_pkg::ITER_W-1:0] count,
                                  logic [aqet_pkg::PIX_W-1:0] index);
            aqet_pkg::t_result want;
            if (owed_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unrequested result, count %0d index %0d", count, index);
                return;
            end
            want = owed_pixels.pop_front();
            if (count !== want.escape_count || index !== want.pixel_index) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: count %0d (want %0d), index %0d (want %0d)",
                             count, want.escape_count, index, want.pixel_index);
            end
        endfunction

        function int owed_count();
            return owed_pixels.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [aqet_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          push;
    logic                          full;
    logic [aqet_pkg::COORD_W-1:0]  i_column;
    logic [aqet_pkg::COORD_W-1:0]  i_row;
    logic                          empty;
    logic                          pop;
    logic [aqet_pkg::ITER_W-1:0]   o_escape_count;
    logic [aqet_pkg::PIX_W-1:0]    o_pixel_index;

    escape_tracker tracker;
    int            pixels_sent = 0;
    int            tx_idle_pct = 25;
    int            rx_idle_pct = 83;
    int            cycle_count = 0;
    int            cols_in_view;
    int            rows_in_view;

    abs_quadratic_escape_time u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .push           (push),
        .full           (full),
        .i_column       (i_column),
        .i_row          (i_row),
        .empty          (empty),
        .pop            (pop),
        .o_escape_count (o_escape_count),
        .o_pixel_index  (o_pixel_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog for a hung block.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: check each popped transaction, stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) tracker.check_pixel(o_escape_count, o_pixel_index);
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // One register write: setup cycle, then access cycle until pready.
    // The bus is left selected so that writes can follow back to back.
    task automatic write_register(input aqet_pkg::t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_register(idx, value);
    endtask

    // Program every register; narrow registers get random bits above their width.
    task automatic apply_view(input logic [15:0] iters, input logic [12:0] w,
                              input logic [12:0] h, input logic [31:0] cre,
                              input logic [31:0] cim, input logic [31:0] sre,
                              input logic [31:0] sim, input logic [31:0] zoom);
        write_register(aqet_pkg::REG_MAX_ITER,  {16'($urandom()), iters});
        write_register(aqet_pkg::REG_WIDTH,     {19'($urandom()), w});
        write_register(aqet_pkg::REG_HEIGHT,    {19'($urandom()), h});
        write_register(aqet_pkg::REG_CENTER_RE, cre);
        write_register(aqet_pkg::REG_CENTER_IM, cim);
        write_register(aqet_pkg::REG_SPAN_RE,   sre);
        write_register(aqet_pkg::REG_SPAN_IM,   sim);
        write_register(aqet_pkg::REG_ZOOM,      zoom);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Push one pixel transaction, with random gaps ahead of it.
    task automatic send_pixel(input logic [aqet_pkg::COORD_W-1:0] col,
                              input logic [aqet_pkg::COORD_W-1:0] row);
        if (pixels_sent < 260) begin
            tx_idle_pct = 25;
            rx_idle_pct = 83;
        end else if (pixels_sent < 520) begin
            tx_idle_pct = 83;
            rx_idle_pct = 25;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        i_column <= col;
        i_row    <= row;
        do @(posedge i_clk); while (full);
        tracker.note_pixel(col, row);
        pixels_sent++;
    endtask

    // Stop pushing and wait until every owed result has been popped.
    task automatic close_phase();
        push <= 1'b0;
        while (tracker.owed_count() != 0) @(posedge i_clk);
    endtask

    function automatic int signed_q(int lo_q, int hi_q);
        return int'($urandom_range(hi_q - lo_q, 0)) + lo_q;
    endfunction

    // Random view; mostly around the interesting region, sometimes anything at all.
    task automatic random_view();
        logic [15:0] iters;
        logic [12:0] w, h;
        int          cre, cim, sre, sim, zoom;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 2)       iters = 16'd0;
        else if (pick < 6)  iters = 16'd1;
        else if (pick < 14) iters = 16'($urandom_range(300, 200));
        else                iters = 16'($urandom_range(64, 2));
        pick = $urandom_range(99);
        if (pick < 10)      w = 13'($urandom_range(8191, 0));
        else if (pick < 40) w = 13'($urandom_range(64, 1));
        else                w = 13'($urandom_range(4096, 65));
        pick = $urandom_range(99);
        if (pick < 10)      h = 13'($urandom_range(8191, 0));
        else if (pick < 40) h = 13'($urandom_range(64, 1));
        else                h = 13'($urandom_range(4096, 65));
        cre  = ($urandom_range(9) == 0) ? int'($urandom()) : signed_q(-2 * ONE_Q, 2 * ONE_Q);
        cim  = ($urandom_range(9) == 0) ? int'($urandom()) : signed_q(-2 * ONE_Q, 2 * ONE_Q);
        sre  = ($urandom_range(9) == 0) ? int'($urandom()) : signed_q(ONE_Q / 4, 4 * ONE_Q);
        sim  = ($urandom_range(9) == 0) ? int'($urandom()) : signed_q(ONE_Q / 4, 4 * ONE_Q);
        zoom = ($urandom_range(9) == 0) ? int'($urandom()) : signed_q(ONE_Q / 2, 2 * ONE_Q);
        if ($urandom_range(9) == 0) sre = -sre;
        if ($urandom_range(9) == 0) sim = -sim;
        cols_in_view = (w == 0) ? 1 :
                       (w > aqet_pkg::MAX_DIM) ? int'(aqet_pkg::MAX_DIM) : int'(w);
        rows_in_view = (h == 0) ? 1 :
                       (h > aqet_pkg::MAX_DIM) ? int'(aqet_pkg::MAX_DIM) : int'(h);
        apply_view(iters, w, h, cre, cim, sre, sim, zoom);
    endtask

    initial begin
        int                           random_sent;
        int                           batch;
        int                           n;
        logic [aqet_pkg::COORD_W-1:0] col, row;

        tracker  = new();
        i_rst_n  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        push     <= 1'b0;
        pop      <= 1'b0;
        i_column <= '0;
        i_row    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default view: corners, the center point that never escapes, indices
        // beyond the view, and alternating bit patterns.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1023, 12'd1023);
        send_pixel(12'd512, 12'd512);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        send_pixel(12'd1023, 12'd0);
        close_phase();

        // Zero iteration limit, zero width, height above the maximum.
        apply_view(16'd0, 13'd0, 13'h1FFF, 32'd0, 32'd0, ONE_Q, ONE_Q, 2 * ONE_Q);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'hFFF, 12'hFFF);
        send_pixel(12'd7, 12'd3);
        close_phase();

        // Single iteration, one-pixel image, every value at its extreme.
        apply_view(16'd1, 13'd1, 13'd1, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd0, 12'd1);
        close_phase();

        // Largest limit and largest image; the center point runs the full limit.
        apply_view(16'hFFFF, 13'd4096, 13'd4096, 32'd0, 32'd0, ONE_Q, ONE_Q, 4 * ONE_Q);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'hFFF, 12'hFFF);
        close_phase();

        // A negative real extent with the most negative zoom saturates the mapping.
        apply_view(16'd64, 13'd8, 13'd4096, -ONE_Q, ONE_Q / 2, -3 * ONE_Q, 3 * ONE_Q,
                   32'h8000_0000);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd7, 12'hFFF);
        send_pixel(12'd3, 12'd100);
        close_phase();

        // Zero zoom puts every pixel on the center point.
        apply_view(16'd200, 13'd100, 13'd50, 7 * ONE_Q / 4, ONE_Q / 20, ONE_Q, ONE_Q, 32'd0);
        send_pixel(12'd10, 12'd10);
        send_pixel(12'd99, 12'd49);
        close_phase();

        // Random views, each with a batch of pixels mostly inside the view.
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            random_view();
            batch = $urandom_range(60, 20);
            for (n = 0; n < batch; n++) begin
                if ($urandom_range(99) < 15) begin
                    col = aqet_pkg::COORD_W'($urandom());
                    row = aqet_pkg::COORD_W'($urandom());
                end else begin
                    col = aqet_pkg::COORD_W'($urandom_range(cols_in_view - 1, 0));
                    row = aqet_pkg::COORD_W'($urandom_range(rows_in_view - 1, 0));
                end
                send_pixel(col, row);
                random_sent++;
            end
            close_phase();
        end

        // Let any stray result show up before the verdict.
        repeat (300) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.owed_count() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/aqet_pkg.sv
hw/rtl/aqet_queue.sv
hw/rtl/aqet_front.sv
hw/rtl/aqet_back.sv
hw/rtl/abs_quadratic_escape_time.sv
tb/sv/abs_quadratic_escape_time_test.sv
